// File: hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds transaction payloads, datapath command/status groups and control codes.
// No dependencies.
`default_nettype none

package tcw_pkg;

   localparam int COL_WIDTH       = 7;
   localparam int ROW_WIDTH       = 5;
   localparam int CHAR_WIDTH      = 8;
   localparam int ATTR_WIDTH      = 7;
   localparam int FG_WIDTH        = 4;
   localparam int BG_WIDTH        = 3;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 4;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FG_COLOR = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BG_COLOR = 4'd1;

   localparam logic [FG_WIDTH-1:0] FG_RESET = 4'd7;
   localparam logic [BG_WIDTH-1:0] BG_RESET = 3'd0;

   // Control codes and fill values
   localparam logic [CHAR_WIDTH-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] BLANK_CHAR = 8'h20;
   localparam logic [ATTR_WIDTH-1:0] RESET_ATTR = 7'h07;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_SET   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_code_type;

   typedef enum logic [2:0] {
      KIND_OTHER = 3'd0,
      KIND_CR    = 3'd1,
      KIND_LF    = 3'd2,
      KIND_TAB   = 3'd3,
      KIND_BS    = 3'd4
   } char_kind_type;

   typedef enum logic [3:0] {
      CUR_HOLD     = 4'd0,
      CUR_HOME     = 4'd1,
      CUR_CR       = 4'd2,
      CUR_LF       = 4'd3,
      CUR_WRAP     = 4'd4,
      CUR_ADV      = 4'd5,
      CUR_BACK     = 4'd6,
      CUR_SET      = 4'd7,
      CUR_LAST_ROW = 4'd8
   } cur_op_type;

   typedef enum logic [2:0] {
      ADDR_HOLD   = 3'd0,
      ADDR_ZERO   = 3'd1,
      ADDR_INC    = 3'd2,
      ADDR_CURSOR = 3'd3,
      ADDR_ITEM   = 3'd4
   } addr_op_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_CHAR  = 2'd1,
      WR_BLANK = 2'd2,
      WR_INIT  = 2'd3
   } wr_op_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic [ATTR_WIDTH-1:0] attr;
   } cell_type;

   typedef struct packed {
      cmd_code_type          cmd;
      logic [CHAR_WIDTH-1:0] char_code;
      logic [COL_WIDTH-1:0]  column;
      logic [ROW_WIDTH-1:0]  row;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] cell_char;
      logic [ATTR_WIDTH-1:0] cell_attr;
      logic [COL_WIDTH-1:0]  cursor_column;
      logic [ROW_WIDTH-1:0]  cursor_row;
      logic                  bad_position;
   } rsp_payload_type;

   typedef struct packed {
      logic        capture;
      cur_op_type  cur_op;
      addr_op_type addr_op;
      wr_op_type   wr_op;
      logic        copy_rd;
      logic        load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      cmd_code_type  item_cmd;
      char_kind_type char_kind;
      logic          at_edge;
      logic          row_over;
      logic          tab_last;
      logic          addr_last;
      logic          copy_last;
      logic          in_range;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: hdl/tcw_datapath.sv
// Datapath of the text console writer: cell memory, cursor, colour registers,
// address counter and response register. Driven by tcw_ctrl; uses tcw_pkg.
`default_nettype none

module tcw_datapath #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tcw_pkg::dp_cmd_type                    dp_cmd,
   output tcw_pkg::dp_stat_type                   dp_stat,
   input  tcw_pkg::req_payload_type               req_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tcw_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tcw_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   output tcw_pkg::rsp_payload_type               rsp_payload
);
   import tcw_pkg::*;

   localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int AW    = $clog2(CELLS);

   localparam logic [COL_WIDTH-1:0] COLS_V    = COL_WIDTH'(SCREEN_COLUMNS);
   localparam logic [ROW_WIDTH-1:0] ROWS_V    = ROW_WIDTH'(SCREEN_ROWS);
   localparam logic [ROW_WIDTH-1:0] LAST_ROW  = ROW_WIDTH'(SCREEN_ROWS - 1);
   localparam logic [AW-1:0]        MUL_COLS  = AW'(SCREEN_COLUMNS);
   localparam logic [AW-1:0]        LAST_ADDR = AW'(CELLS - 1);
   localparam logic [AW-1:0]        COPY_LAST = AW'(CELLS - SCREEN_COLUMNS - 1);

   cell_type                cell_mem [CELLS];

   req_payload_type         item_ff, item_in;
   logic [COL_WIDTH-1:0]    cc_ff, cc_in;
   logic [ROW_WIDTH-1:0]    cr_ff, cr_in;
   logic [FG_WIDTH-1:0]     fg_ff, fg_in;
   logic [BG_WIDTH-1:0]     bg_ff, bg_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [AW-1:0]           copy_addr_ff, copy_addr_in;
   logic                    pend_ff, pend_in;
   cell_type                rdata_ff;
   rsp_payload_type         rsp_ff, rsp_in;

   logic [ATTR_WIDTH-1:0]   attr_now;
   logic                    col_ok, row_ok, at_edge, is_read;
   logic [COL_WIDTH-1:0]    col_sel;
   logic [ROW_WIDTH-1:0]    row_sel;
   logic [AW-1:0]           addr_calc;
   logic [AW-1:0]           mem_raddr;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   cell_type                mem_wdata;
   char_kind_type           char_kind;

   assign attr_now  = {bg_ff, fg_ff};
   assign col_ok    = item_ff.column < COLS_V;
   assign row_ok    = item_ff.row < ROWS_V;
   assign at_edge   = cc_ff >= COLS_V;
   assign is_read   = item_ff.cmd == CMD_READ;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_in = csr_data[FG_WIDTH-1:0];
            CSR_BG_COLOR: bg_in = csr_data[BG_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign item_in = dp_cmd.capture ? req_payload : item_ff;

   always_comb begin
      unique case (item_ff.char_code)
         CHAR_CR:  char_kind = KIND_CR;
         CHAR_LF:  char_kind = KIND_LF;
         CHAR_TAB: char_kind = KIND_TAB;
         CHAR_BS:  char_kind = KIND_BS;
         default:  char_kind = KIND_OTHER;
      endcase
   end

   // Cursor update
   always_comb begin
      cc_in = cc_ff;
      cr_in = cr_ff;
      unique case (dp_cmd.cur_op)
         CUR_HOLD: begin
         end
         CUR_HOME: begin
            cc_in = '0;
            cr_in = '0;
         end
         CUR_CR: cc_in = '0;
         CUR_LF: begin
            cc_in = '0;
            cr_in = cr_ff + ROW_WIDTH'(1);
         end
         CUR_WRAP: begin
            if (at_edge) begin
               cc_in = '0;
               cr_in = cr_ff + ROW_WIDTH'(1);
            end
         end
         CUR_ADV: cc_in = cc_ff + COL_WIDTH'(1);
         CUR_BACK: begin
            if (cc_ff != '0) begin
               cc_in = cc_ff - COL_WIDTH'(1);
            end
         end
         CUR_SET: begin
            if (col_ok) begin
               cc_in = item_ff.column;
            end
            if (row_ok) begin
               cr_in = item_ff.row;
            end
         end
         CUR_LAST_ROW: cr_in = LAST_ROW;
         default: begin
         end
      endcase
   end

   // Cell address: row times width plus column
   assign col_sel   = (dp_cmd.addr_op == ADDR_ITEM) ? item_ff.column : cc_ff;
   assign row_sel   = (dp_cmd.addr_op == ADDR_ITEM) ? item_ff.row : cr_ff;
   assign addr_calc = AW'(AW'(row_sel) * MUL_COLS) + AW'(col_sel);

   always_comb begin
      unique case (dp_cmd.addr_op)
         ADDR_HOLD:   addr_in = addr_ff;
         ADDR_ZERO:   addr_in = '0;
         ADDR_INC:    addr_in = addr_ff + AW'(1);
         ADDR_CURSOR: addr_in = addr_calc;
         ADDR_ITEM:   addr_in = addr_calc;
         default:     addr_in = addr_ff;
      endcase
   end

   // Scroll copy: read one row ahead, write the registered cell back in the next cycle
   assign mem_raddr    = dp_cmd.copy_rd ? (addr_ff + MUL_COLS) : addr_ff;
   assign copy_addr_in = addr_ff;
   assign pend_in      = dp_cmd.copy_rd;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '{ch: BLANK_CHAR, attr: attr_now};
      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_addr_ff;
         mem_wdata = rdata_ff;
      end else begin
         unique case (dp_cmd.wr_op)
            WR_NONE: begin
            end
            WR_CHAR: begin
               mem_we       = 1'b1;
               mem_wdata.ch = item_ff.char_code;
            end
            WR_BLANK: mem_we = 1'b1;
            WR_INIT: begin
               mem_we         = 1'b1;
               mem_wdata.attr = RESET_ATTR;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= cell_mem[mem_raddr];
   end

   // Response register
   always_comb begin
      rsp_in = rsp_ff;
      if (dp_cmd.load_rsp) begin
         rsp_in.cell_char     = (is_read && col_ok && row_ok) ? rdata_ff.ch : '0;
         rsp_in.cell_attr     = (is_read && col_ok && row_ok) ? rdata_ff.attr : '0;
         rsp_in.cursor_column = cc_ff;
         rsp_in.cursor_row    = cr_ff;
         rsp_in.bad_position  = is_read && !(col_ok && row_ok);
      end
   end

   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff   <= '0;
         cr_ff   <= '0;
         fg_ff   <= FG_RESET;
         bg_ff   <= BG_RESET;
         addr_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         cc_ff   <= cc_in;
         cr_ff   <= cr_in;
         fg_ff   <= fg_in;
         bg_ff   <= bg_in;
         addr_ff <= addr_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      copy_addr_ff <= copy_addr_in;
      rsp_ff       <= rsp_in;
   end

   // Status to the controller
   always_comb begin
      dp_stat.item_cmd  = item_ff.cmd;
      dp_stat.char_kind = char_kind;
      dp_stat.at_edge   = at_edge;
      dp_stat.row_over  = cr_ff >= ROWS_V;
      dp_stat.tab_last  = (cc_ff[1:0] == 2'b11) || (cc_ff == COLS_V - COL_WIDTH'(1));
      dp_stat.addr_last = addr_ff == LAST_ADDR;
      dp_stat.copy_last = addr_ff == COPY_LAST;
      dp_stat.in_range  = col_ok && row_ok;
   end

   a_copy_exclusive: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (dp_cmd.wr_op == WR_NONE))
      else $error("scroll copy write collides with another cell write");

   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.capture |-> ((cr_ff < ROWS_V) && (cc_ff <= COLS_V)))
      else $error("cursor out of bounds when a transaction is taken");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr <= LAST_ADDR))
      else $error("cell write beyond the screen");

endmodule

`default_nettype wire

// File: hdl/tcw_ctrl.sv
// Controller of the text console writer: sequences each command and the
// memory walks (reset fill, clear, scroll). Uses tcw_pkg.
`default_nettype none

module tcw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcw_pkg::dp_cmd_type   dp_cmd,
   input  tcw_pkg::dp_stat_type  dp_stat
);
   import tcw_pkg::*;

   typedef enum logic [11:0] {
      S_INIT   = 12'b000000000001,
      S_IDLE   = 12'b000000000010,
      S_DECODE = 12'b000000000100,
      S_SETTLE = 12'b000000001000,
      S_WRITE  = 12'b000000010000,
      S_TAB    = 12'b000000100000,
      S_CLEAR  = 12'b000001000000,
      S_SCROLL = 12'b000010000000,
      S_DRAIN  = 12'b000100000000,
      S_BLANK  = 12'b001000000000,
      S_READ   = 12'b010000000000,
      S_DONE   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '{capture: 1'b0, cur_op: CUR_HOLD, addr_op: ADDR_HOLD,
                   wr_op: WR_NONE, copy_rd: 1'b0, load_rsp: 1'b0};
      unique case (state_ff)
         S_INIT: begin
            dp_cmd.wr_op   = WR_INIT;
            dp_cmd.addr_op = ADDR_INC;
            if (dp_stat.addr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (dp_stat.item_cmd)
               CMD_PUT: begin
                  unique case (dp_stat.char_kind)
                     KIND_CR: begin
                        dp_cmd.cur_op = CUR_CR;
                        state_in      = S_DONE;
                     end
                     KIND_LF: begin
                        dp_cmd.cur_op = CUR_LF;
                        state_in      = S_SETTLE;
                     end
                     KIND_BS: begin
                        dp_cmd.cur_op = CUR_BACK;
                        state_in      = S_DONE;
                     end
                     KIND_TAB: begin
                        if (dp_stat.at_edge) begin
                           state_in = S_DONE;
                        end else begin
                           dp_cmd.addr_op = ADDR_CURSOR;
                           state_in       = S_TAB;
                        end
                     end
                     default: begin
                        dp_cmd.cur_op = CUR_WRAP;
                        state_in      = S_SETTLE;
                     end
                  endcase
               end
               CMD_CLEAR: begin
                  dp_cmd.addr_op = ADDR_ZERO;
                  dp_cmd.cur_op  = CUR_HOME;
                  state_in       = S_CLEAR;
               end
               CMD_SET: begin
                  dp_cmd.cur_op = CUR_SET;
                  state_in      = S_DONE;
               end
               CMD_READ: begin
                  if (dp_stat.in_range) begin
                     dp_cmd.addr_op = ADDR_ITEM;
                     state_in       = S_READ;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            endcase
         end
         S_SETTLE: begin
            priority if (dp_stat.row_over) begin
               dp_cmd.addr_op = ADDR_ZERO;
               dp_cmd.cur_op  = CUR_LAST_ROW;
               state_in       = S_SCROLL;
            end else if (dp_stat.char_kind == KIND_OTHER) begin
               dp_cmd.addr_op = ADDR_CURSOR;
               state_in       = S_WRITE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WRITE: begin
            dp_cmd.wr_op  = WR_CHAR;
            dp_cmd.cur_op = CUR_ADV;
            state_in      = S_DONE;
         end
         S_TAB: begin
            dp_cmd.wr_op   = WR_BLANK;
            dp_cmd.addr_op = ADDR_INC;
            dp_cmd.cur_op  = CUR_ADV;
            if (dp_stat.tab_last) begin
               state_in = S_DONE;
            end
         end
         S_CLEAR: begin
            dp_cmd.wr_op   = WR_BLANK;
            dp_cmd.addr_op = ADDR_INC;
            if (dp_stat.addr_last) begin
               state_in = S_DONE;
            end
         end
         S_SCROLL: begin
            dp_cmd.copy_rd = 1'b1;
            dp_cmd.addr_op = ADDR_INC;
            if (dp_stat.copy_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_BLANK;
         end
         S_BLANK: begin
            dp_cmd.wr_op   = WR_BLANK;
            dp_cmd.addr_op = ADDR_INC;
            if (dp_stat.addr_last) begin
               state_in = S_SETTLE;
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      priority if (dp_cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL) |-> !dp_stat.row_over)
      else $error("cursor row not pulled back to the last row during scroll");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response loaded over one not yet taken");

endmodule

`default_nettype wire

// File: hdl/text_console_writer.sv
// Top level of the text console writer: joins controller and datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall   tcw_pkg::req_payload_type
//   rsp_      out        rsp_valid/rsp_stall   tcw_pkg::rsp_payload_type
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// Each transaction is decoded and completed; tab, clear and a scroll also walk the
//   cell memory: a tab pads blank cells up to the next tab stop (up to 4), clear
//   blanks every cell, and a scroll copies each row up and blanks the last row.
// After reset a fill pass writes every cell with req_stall high; csr writes are taken.
// One transaction is in work at a time; the response register lets the next
//   request be taken while a result waits, and rsp_stall holds only completion.
`default_nettype none

module text_console_writer #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tcw_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tcw_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcw_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tcw_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import tcw_pkg::*;

   // Command and status between the sequencer and the datapath
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // Sequence each transaction: decode, walk memory where needed, complete
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   // Hold the screen, cursor, colours and the response register
   tcw_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .dp_stat     (dp_stat),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
